FILE: sv/polyline_length_accumulator_defines.svh
// ----------------------------------------------------------------------------
// polyline_length_accumulator_defines.svh
// assertion macros shared by the polyline length accumulator
// ----------------------------------------------------------------------------
`ifndef POLYLINE_LENGTH_ACCUMULATOR_DEFINES_SVH
`define POLYLINE_LENGTH_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTH

// property checked on every clock edge outside reset
`define PLAC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define PLAC_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define PLAC_ASSERT(name, clk, rst_n, prop, msg)
`define PLAC_ASSERT_NEXT(name, clk, rst_n, pre, post, msg)

`endif

`endif

FILE: sv/plac_pkg.sv
// ----------------------------------------------------------------------------
// plac_pkg
// types shared by the controller and datapath of the path length accumulator
// ----------------------------------------------------------------------------
package plac_pkg;

  // operand select for the shared squaring multiplier
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // controller to datapath commands
  typedef struct packed {
    logic  take;        // capture vertex, differences and last flag
    logic  start_path;  // open a new path at the captured vertex
    logic  mul_en;      // square the selected difference
    axis_e mul_sel;
    logic  acc_clr;     // clear sum of squares
    logic  acc_add;     // add last product to sum of squares
    logic  root_load;   // load radicand, clear root and remainder
    logic  root_step;   // one restoring square root iteration
    logic  len_add;     // add root to running length, saturating
    logic  out_load;    // load result register and close the path
  } plac_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic start_req;  // offered vertex opens a path
    logic last;       // captured vertex ends the path
    logic out_busy;   // result register still held by the receiver
  } plac_sts_t;

endpackage

FILE: sv/plac_ctrl.sv
// ----------------------------------------------------------------------------
// plac_ctrl
// sequencer for squaring, square root, accumulation and result hand-off
// ----------------------------------------------------------------------------
module plac_ctrl #(
  parameter int ROOT_W = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  plac_pkg::plac_sts_t sts_i,
  output plac_pkg::plac_cmd_t cmd_o
);
  import plac_pkg::*;

  localparam int CntW = $clog2(ROOT_W);
  localparam logic [CntW-1:0] CntLast = CntW'(ROOT_W - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQ0   = 3'd1;
  localparam logic [2:0] S_SQ1   = 3'd2;
  localparam logic [2:0] S_SQ2   = 3'd3;
  localparam logic [2:0] S_SQ3   = 3'd4;
  localparam logic [2:0] S_ROOT  = 3'd5;
  localparam logic [2:0] S_ACCUM = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.start_req) begin
            cmd_o.start_path = 1'b1;
            state_d          = S_FIN;
          end else begin
            state_d = S_SQ0;
          end
        end
      end
      S_SQ0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = AXIS_X;
        cmd_o.acc_clr = 1'b1;
        state_d       = S_SQ1;
      end
      S_SQ1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = AXIS_Y;
        cmd_o.acc_add = 1'b1;
        state_d       = S_SQ2;
      end
      S_SQ2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = AXIS_Z;
        cmd_o.acc_add = 1'b1;
        state_d       = S_SQ3;
      end
      S_SQ3: begin
        cmd_o.root_load = 1'b1;
        cnt_d           = CntLast;
        state_d         = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_ACCUM;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_ACCUM: begin
        cmd_o.len_add = 1'b1;
        state_d       = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: sv/plac_dpath.sv
// ----------------------------------------------------------------------------
// plac_dpath
// vertex registers, shared squarer, restoring square root and length sum
// ----------------------------------------------------------------------------
module plac_dpath #(
  parameter int COORD_BITS  = 24,
  parameter int LENGTH_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic signed [COORD_BITS-1:0]  pos_x_i,
  input  logic signed [COORD_BITS-1:0]  pos_y_i,
  input  logic signed [COORD_BITS-1:0]  pos_z_i,
  input  logic                          is_first_i,
  input  logic                          is_last_i,
  input  plac_pkg::plac_cmd_t           cmd_i,
  output plac_pkg::plac_sts_t           sts_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic        [LENGTH_BITS-1:0] path_length_o,
  output logic                          saturated_o
);
  import plac_pkg::*;

  localparam int DiffW = COORD_BITS + 1;
  localparam int ProdW = 2 * COORD_BITS;
  localparam int SumW  = 2 * COORD_BITS + 2;
  localparam int RootW = COORD_BITS + 1;
  localparam int RemW  = RootW + 2;
  localparam int AccW  = ((LENGTH_BITS > RootW) ? LENGTH_BITS : RootW) + 1;
  localparam logic [AccW-1:0] LenMax =
    {{(AccW - LENGTH_BITS){1'b0}}, {LENGTH_BITS{1'b1}}};

  logic                   horizontal_only_q;
  logic                   in_path_q;
  logic                   ovf_q;
  logic [LENGTH_BITS-1:0] run_q;
  logic                   out_valid_q;
  logic                   last_q;

  logic [COORD_BITS-1:0]  prev_x_q, prev_y_q, prev_z_q;
  logic [COORD_BITS-1:0]  abs_q [3];
  logic [ProdW-1:0]       prod_q;
  logic [SumW-1:0]        acc_q;
  logic [SumW-1:0]        rad_q;
  logic [RemW-1:0]        rem_q;
  logic [RootW-1:0]       root_q;
  logic [LENGTH_BITS-1:0] path_length_q;
  logic                   saturated_q;

  logic [DiffW-1:0]       dx, dy, dz;
  logic [COORD_BITS-1:0]  ax, ay, az;
  logic [COORD_BITS-1:0]  mul_op;
  logic [RemW-1:0]        rem_shift;
  logic [RemW-1:0]        trial;
  logic                   fits;
  logic [AccW-1:0]        len_sum;

  // differences to the previous vertex, sign taken from the extra bit
  assign dx = {pos_x_i[COORD_BITS-1], pos_x_i} - {prev_x_q[COORD_BITS-1], prev_x_q};
  assign dy = {pos_y_i[COORD_BITS-1], pos_y_i} - {prev_y_q[COORD_BITS-1], prev_y_q};
  assign dz = {pos_z_i[COORD_BITS-1], pos_z_i} - {prev_z_q[COORD_BITS-1], prev_z_q};

  assign ax = dx[DiffW-1] ? COORD_BITS'(~dx + 1'b1) : dx[COORD_BITS-1:0];
  assign ay = dy[DiffW-1] ? COORD_BITS'(~dy + 1'b1) : dy[COORD_BITS-1:0];
  assign az = dz[DiffW-1] ? COORD_BITS'(~dz + 1'b1) : dz[COORD_BITS-1:0];

  always_comb begin
    case (cmd_i.mul_sel)
      AXIS_X:  mul_op = abs_q[0];
      AXIS_Y:  mul_op = abs_q[1];
      AXIS_Z:  mul_op = abs_q[2];
      default: mul_op = '0;
    endcase
  end

  // one restoring root iteration: two radicand bits in, one root bit out
  assign rem_shift = {rem_q[RemW-3:0], rad_q[SumW-1 -: 2]};
  assign trial     = {root_q, 2'b01};
  assign fits      = (rem_shift >= trial);

  assign len_sum = AccW'(run_q) + AccW'(root_q);

  assign sts_o.start_req = is_first_i || !in_path_q;
  assign sts_o.last      = last_q;
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign path_length_o = path_length_q;
  assign saturated_o   = saturated_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horizontal_only_q <= 1'b0;
      in_path_q         <= 1'b0;
      ovf_q             <= 1'b0;
      run_q             <= '0;
      out_valid_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        horizontal_only_q <= cfg_wdata_i;
      end
      if (cmd_i.start_path) begin
        in_path_q <= 1'b1;
        ovf_q     <= 1'b0;
        run_q     <= '0;
      end else if (cmd_i.len_add) begin
        if (len_sum >= LenMax) begin
          run_q <= {LENGTH_BITS{1'b1}};
          ovf_q <= 1'b1;
        end else begin
          run_q <= len_sum[LENGTH_BITS-1:0];
        end
      end else if (cmd_i.out_load) begin
        in_path_q <= 1'b0;
        ovf_q     <= 1'b0;
        run_q     <= '0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      prev_x_q <= pos_x_i;
      prev_y_q <= pos_y_i;
      prev_z_q <= pos_z_i;
      abs_q[0] <= ax;
      abs_q[1] <= ay;
      abs_q[2] <= horizontal_only_q ? '0 : az;
      last_q   <= is_last_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_op * mul_op;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + SumW'(prod_q);
    end
    if (cmd_i.root_load) begin
      rad_q  <= acc_q + SumW'(prod_q);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q <= {rad_q[SumW-3:0], 2'b00};
      if (fits) begin
        rem_q  <= rem_shift - trial;
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_shift;
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      path_length_q <= run_q;
      saturated_q   <= ovf_q;
    end
  end

endmodule

FILE: sv/polyline_length_accumulator.sv
// ----------------------------------------------------------------------------
// polyline_length_accumulator
// running euclidean length of a streamed ray path, one total per path
// ----------------------------------------------------------------------------
// vertices arrive on the input channel (in_valid_i / in_stall_o) with is_first
// on the source and is_last on the final vertex; one transaction leaves on the
// output channel (out_valid_o / out_stall_i) for each vertex with is_last set.
// a vertex that opens a path goes from idle straight to the final state; a later
// vertex gets three squarings on one shared multiplier, the restoring square
// root that resolves one root bit per cycle, and the saturating add; for a last
// vertex the total is loaded into the output register from the final state
// once any held result has gone. horizontal_only is written through cfg_we_i /
// cfg_wdata_i only while idle; the user must keep to this, the block does not
// enforce it. reset closes any open path, clears horizontal_only and drops
// out_valid_o. a stalled result holds; the next vertices are still taken, and
// only the next last vertex waits until the held result has gone.
// ----------------------------------------------------------------------------
`include "polyline_length_accumulator_defines.svh"

module polyline_length_accumulator #(
  parameter int COORD_BITS  = 24,
  parameter int LENGTH_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  // vertex input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_BITS-1:0]  pos_x_i,
  input  logic signed [COORD_BITS-1:0]  pos_y_i,
  input  logic signed [COORD_BITS-1:0]  pos_z_i,
  input  logic                          is_first_i,
  input  logic                          is_last_i,
  // path result
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic        [LENGTH_BITS-1:0] path_length_o,
  output logic                          saturated_o
);
  import plac_pkg::*;

  // square root width follows from the largest sum of squares
  localparam int RootW = COORD_BITS + 1;

  plac_cmd_t cmd;
  plac_sts_t sts;

  // sequencer: owns the state and the root iteration count
  plac_ctrl #(
    .ROOT_W (RootW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: vertex, squarer, root, running length and result register
  plac_dpath #(
    .COORD_BITS  (COORD_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .is_first_i    (is_first_i),
    .is_last_i     (is_last_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .path_length_o (path_length_o),
    .saturated_o   (saturated_o)
  );

  // the block is busy in the cycle after it takes a vertex
  `PLAC_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "vertex taken but block not busy next cycle")

  // a new result never overwrites one the receiver still holds
  `PLAC_ASSERT(a_no_result_overwrite, clk_i, rst_ni, !(cmd.out_load && out_valid_o && out_stall_i), "result loaded over a stalled result")

  // squaring, root, accumulation and hand-off belong to distinct steps
  `PLAC_ASSERT(a_steps_exclusive, clk_i, rst_ni, $onehot0({cmd.mul_en, cmd.root_step, cmd.len_add, cmd.out_load}), "datapath steps overlap")

  // a saturated total is the maximum length
  `PLAC_ASSERT(a_sat_means_max, clk_i, rst_ni, !(out_valid_o && saturated_o) || (path_length_o == {LENGTH_BITS{1'b1}}), "saturated flag with total below maximum")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the polyline length accumulator
// ----------------------------------------------------------------------------
// vertices go in from a queue through a clocked driver. a clocked monitor
// follows each accepted vertex with its own path length tracker and queues the
// expected total when a path closes. a second monitor compares every path
// total that leaves the block against those expectations. the run walks both
// settings of horizontal_only, with directed corner cases, long paths that
// land on and past the saturation point, and random paths and stray vertices
// ----------------------------------------------------------------------------
module testbench;

  localparam int COORD_W       = 24;
  localparam int LENGTH_W      = 32;
  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 64;    // square root pass plus output register, with margin
  localparam int STUCK_LIMIT   = 4000;  // cycles with no transaction on either channel
  localparam int RANDOM_ITEMS  = 1130;
  localparam int RANDOM_PHASES = 4;
  localparam int IDLE_PCT      = 38;

  localparam int C_LO = -8388608;
  localparam int C_HI = 8388607;

  localparam longint unsigned LENGTH_MAX = 64'hFFFF_FFFF;
  localparam longint unsigned SPAN       = 64'd16777215;  // full coordinate swing

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   first;
    logic   last;
  } vertex_t;

  typedef struct packed {
    logic [LENGTH_W-1:0] length;
    logic                clipped;
  } path_total_t;

  // block ports
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_wdata_i = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  coord_t              pos_x_i     = '0;
  coord_t              pos_y_i     = '0;
  coord_t              pos_z_i     = '0;
  logic                is_first_i  = 1'b0;
  logic                is_last_i   = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [LENGTH_W-1:0] path_length_o;
  logic                saturated_o;

  // stimulus and expectations
  vertex_t     pend_q[$];
  path_total_t totals_due[$];
  logic        steady = 1'b0;  // no idling on either side while set
  int          queued_items;
  int          stuck_cycles = 0;

  // path length tracker
  logic                horiz_mode;
  coord_t              trace_x, trace_y, trace_z;
  logic [LENGTH_W-1:0] trace_len;
  logic                trace_open;
  logic                trace_clipped;

  // run statistics
  int mismatches     = 0;
  int vertices_taken = 0;
  int totals_checked = 0;
  int clipped_totals = 0;
  int mode_writes    = 0;

  polyline_length_accumulator #(
    .COORD_BITS (COORD_W),
    .LENGTH_BITS(LENGTH_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .is_first_i   (is_first_i),
    .is_last_i    (is_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .path_length_o(path_length_o),
    .saturated_o  (saturated_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic logic take_pause();
    return !steady && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // floor of the square root, one root bit per pass
  function automatic longint unsigned isqrt_floor(input longint unsigned radicand);
    longint unsigned remainder_v;
    longint unsigned root;
    longint unsigned trial;
    remainder_v = 0;
    root        = 0;
    for (int k = 31; k >= 0; k--) begin
      remainder_v = (remainder_v << 2) | ((radicand >> (2 * k)) & 64'd3);
      trial       = (root << 2) | 64'd1;
      if (remainder_v >= trial) begin
        remainder_v = remainder_v - trial;
        root        = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // distance from the traced vertex, z dropped in horizontal mode
  function automatic longint unsigned segment_length(input vertex_t v);
    longint ax, ay, az, bx, by, bz, dx, dy, dz;
    ax = longint'(v.x);
    ay = longint'(v.y);
    az = longint'(v.z);
    bx = longint'(trace_x);
    by = longint'(trace_y);
    bz = longint'(trace_z);
    dx = ax - bx;
    dy = ay - by;
    dz = horiz_mode ? 64'sd0 : az - bz;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dz < 0) dz = -dz;
    return isqrt_floor(longint'(dx * dx + dy * dy + dz * dz));
  endfunction

  function automatic void clear_trace();
    trace_x       = '0;
    trace_y       = '0;
    trace_z       = '0;
    trace_len     = '0;
    trace_open    = 1'b0;
    trace_clipped = 1'b0;
  endfunction

  // follow one accepted vertex; a closing vertex queues the expected total
  function automatic void advance_path(input vertex_t v);
    longint unsigned sum;
    path_total_t     total;
    if (v.first || !trace_open) begin
      // source vertex, or a stray vertex opening a path of its own
      trace_len     = '0;
      trace_clipped = 1'b0;
      trace_open    = 1'b1;
    end else begin
      sum = longint'(trace_len) + segment_length(v);
      if (sum >= LENGTH_MAX) begin
        sum           = LENGTH_MAX;
        trace_clipped = 1'b1;
      end
      trace_len = sum[LENGTH_W-1:0];
    end
    trace_x = v.x;
    trace_y = v.y;
    trace_z = v.z;
    if (v.last) begin
      total.length  = trace_len;
      total.clipped = trace_clipped;
      totals_due    = {totals_due, total};
      clear_trace();
    end
  endfunction

  function automatic vertex_t make_vertex(input int x, input int y, input int z,
                                          input logic first, input logic last);
    vertex_t v;
    v.x     = x[COORD_W-1:0];
    v.y     = y[COORD_W-1:0];
    v.z     = z[COORD_W-1:0];
    v.first = first;
    v.last  = last;
    return v;
  endfunction

  // mostly full-range values, some extremes and some near zero
  function automatic coord_t rand_coord();
    logic [31:0] r;
    int          s;
    int unsigned pick;
    pick = $urandom_range(99);
    r    = $urandom;
    if (pick < 70) begin
      return r[COORD_W-1:0];
    end else if (pick < 85) begin
      case (r[1:0])
        2'd0:    s = C_LO;
        2'd1:    s = C_HI;
        2'd2:    s = 0;
        default: s = -1;
      endcase
    end else begin
      s = int'($urandom_range(511)) - 256;
    end
    return s[COORD_W-1:0];
  endfunction

  // step of random magnitude away from a coordinate, clamped to the range
  function automatic coord_t nudge(input coord_t c);
    int t;
    int step;
    step = int'($urandom_range(1 << $urandom_range(22)));
    t    = int'(c);
    t    = $urandom_range(1) ? t + step : t - step;
    if (t > C_HI) t = C_HI;
    if (t < C_LO) t = C_LO;
    return t[COORD_W-1:0];
  endfunction

  task automatic queue_vertex(input vertex_t v);
    pend_q = {pend_q, v};
    queued_items++;
  endtask

  // one well-formed path with random content, or now and then a stray vertex
  task automatic queue_random_path();
    vertex_t v;
    int      mids;
    v.x = rand_coord();
    v.y = rand_coord();
    v.z = rand_coord();
    if ($urandom_range(99) < 12) begin
      v.first = 1'($urandom_range(1));
      v.last  = 1'($urandom_range(1));
      queue_vertex(v);
    end else begin
      mids    = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(4);
      v.first = 1'b1;
      v.last  = 1'b0;
      queue_vertex(v);
      for (int i = 0; i <= mids; i++) begin
        v.first = 1'b0;
        v.last  = (i == mids);
        if ($urandom_range(1)) begin
          v.x = rand_coord();
          v.y = rand_coord();
          v.z = rand_coord();
        end else begin
          v.x = nudge(v.x);
          v.y = nudge(v.y);
          v.z = nudge(v.z);
        end
        queue_vertex(v);
      end
    end
  endtask

  // corner to corner hops, then single-axis moves that land the sum on goal;
  // extra hops afterwards push the sum past it
  task automatic queue_boundary_path(input longint unsigned goal, input int extra);
    vertex_t         path_q[$];
    vertex_t         v;
    longint unsigned sum;
    longint unsigned diag;
    longint unsigned step;
    int              t;
    diag = isqrt_floor((horiz_mode ? 64'd2 : 64'd3) * SPAN * SPAN);
    sum  = 0;
    v    = make_vertex(C_LO, C_LO, C_LO, 1'b1, 1'b0);
    path_q = {path_q, v};
    v.first = 1'b0;
    while (sum < goal) begin
      if (goal - sum >= diag + SPAN) begin
        v.x = ~v.x;
        v.y = ~v.y;
        v.z = ~v.z;
        sum = sum + diag;
      end else begin
        step = (goal - sum < SPAN) ? goal - sum : SPAN;
        t    = (v.x == C_HI[COORD_W-1:0]) ? C_HI - int'(step) : C_LO + int'(step);
        v.x  = t[COORD_W-1:0];
        sum  = sum + step;
      end
      path_q = {path_q, v};
    end
    repeat (extra) begin
      v.x = ~v.x;
      v.y = ~v.y;
      v.z = ~v.z;
      path_q = {path_q, v};
    end
    v      = path_q.pop_back();
    v.last = 1'b1;
    path_q = {path_q, v};
    foreach (path_q[i]) queue_vertex(path_q[i]);
  endtask

  // every queued vertex taken, every total back, and the block quiet again
  task automatic wait_idle();
    while (pend_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (totals_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    horiz_mode = val;
    mode_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // vertex driver: payload holds while stalled, random gaps between items
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_vertices
    vertex_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pend_q.size() != 0 && !take_pause()) begin
        nxt = pend_q.pop_front();
        in_valid_i <= 1'b1;
        pos_x_i    <= nxt.x;
        pos_y_i    <= nxt.y;
        pos_z_i    <= nxt.z;
        is_first_i <= nxt.first;
        is_last_i  <= nxt.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver stalls at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= take_pause();
    end
  end

  // input monitor: every accepted vertex advances the tracker
  always @(posedge clk_i) begin : watch_vertices
    vertex_t seen;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      seen.x     = pos_x_i;
      seen.y     = pos_y_i;
      seen.z     = pos_z_i;
      seen.first = is_first_i;
      seen.last  = is_last_i;
      advance_path(seen);
      vertices_taken++;
    end
  end

  // output monitor: each path total against the oldest expectation
  always @(posedge clk_i) begin : check_totals
    path_total_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (totals_due.size() == 0) begin
        flag_mismatch($sformatf("path total %0d with no path closed", path_length_o));
      end else begin
        want = totals_due.pop_front();
        totals_checked++;
        if (want.clipped) clipped_totals++;
        if (path_length_o !== want.length) begin
          flag_mismatch($sformatf("path_length %0d, expected %0d",
                                  path_length_o, want.length));
        end
        if (saturated_o !== want.clipped) begin
          flag_mismatch($sformatf("saturated %b, expected %b (length %0d)",
                                  saturated_o, want.clipped, want.length));
        end
      end
    end
  end

  // watchdog: counts cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("timeout: no transaction for %0d cycles, %0d totals outstanding",
             STUCK_LIMIT, totals_due.size());
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase_goal;
    horiz_mode   = 1'b0;
    queued_items = 0;
    clear_trace();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // three-axis mode, directed corner cases
    write_mode(1'b0);
    @(negedge clk_i);
    // lone source and receiver in one vertex
    queue_vertex(make_vertex(0, 0, 0, 1'b1, 1'b1));
    // opposite corners of the coordinate range
    queue_vertex(make_vertex(C_LO, C_LO, C_LO, 1'b1, 1'b0));
    queue_vertex(make_vertex(C_HI, C_HI, C_HI, 1'b0, 1'b1));
    // new source while a path is open drops the old path
    queue_vertex(make_vertex(100, 200, 300, 1'b1, 1'b0));
    queue_vertex(make_vertex(1000, -5, 7, 1'b0, 1'b0));
    queue_vertex(make_vertex(C_HI, C_LO, 0, 1'b1, 1'b0));
    queue_vertex(make_vertex(-1, -1, -1, 1'b0, 1'b1));
    // closing vertex with no path open
    queue_vertex(make_vertex(5, 5, 5, 1'b0, 1'b1));
    // unflagged vertex with no path open starts one, 3-4-5 segment follows
    queue_vertex(make_vertex(0, 0, 0, 1'b0, 1'b0));
    queue_vertex(make_vertex(768, 1024, 0, 1'b0, 1'b1));
    // source and receiver flags together while a path is open
    queue_vertex(make_vertex(1, 2, 3, 1'b1, 1'b0));
    queue_vertex(make_vertex(7, 8, 9, 1'b1, 1'b1));
    // zero-length segment
    queue_vertex(make_vertex(-1, 0, C_HI, 1'b1, 1'b0));
    queue_vertex(make_vertex(-1, 0, C_HI, 1'b0, 1'b1));
    // z-only segment, full swing
    queue_vertex(make_vertex(0, 0, C_LO, 1'b1, 1'b0));
    queue_vertex(make_vertex(0, 0, C_HI, 1'b0, 1'b1));
    wait_idle();

    // horizontal mode: z must drop out
    write_mode(1'b1);
    @(negedge clk_i);
    queue_vertex(make_vertex(0, 0, C_LO, 1'b1, 1'b0));
    queue_vertex(make_vertex(0, 0, C_HI, 1'b0, 1'b1));
    queue_vertex(make_vertex(C_LO, C_LO, C_LO, 1'b1, 1'b0));
    queue_vertex(make_vertex(C_HI, C_HI, C_HI, 1'b0, 1'b1));
    queue_vertex(make_vertex(0, 0, 0, 1'b0, 1'b0));
    queue_vertex(make_vertex(768, 1024, 4095, 1'b0, 1'b1));
    wait_idle();

    // random phases alternate the mode; one runs without any idling
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_mode(phase[0]);
      steady = (phase == 2);
      phase_goal = queued_items + RANDOM_ITEMS / RANDOM_PHASES;
      @(negedge clk_i);
      if (phase == 0) begin
        // sum stops one short of the ceiling, no saturation
        queue_boundary_path(LENGTH_MAX - 1, 0);
      end else if (phase == 1) begin
        // sum reaches the ceiling exactly, then keeps going
        queue_boundary_path(LENGTH_MAX, 3);
      end
      while (queued_items < phase_goal) queue_random_path();
      // close whatever a stray vertex may have left open
      queue_vertex(make_vertex(int'(rand_coord()), int'(rand_coord()),
                               int'(rand_coord()), 1'b0, 1'b1));
      wait_idle();
    end
    steady = 1'b0;

    $display("checked %0d path totals (%0d saturated) from %0d accepted vertices",
             totals_checked, clipped_totals, vertices_taken);
    $display("horizontal_only written %0d times, both settings used, %0d mismatches",
             mode_writes, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
